/* sv/gimli_pkg.sv */
// ----------------------------------------------------------------------------
// gimli_pkg
// shared types, constants and the round constant helper for the gimli permutation core
// ----------------------------------------------------------------------------
package gimli_pkg;

   localparam int unsigned ROUND_COUNT = 24;
   localparam int unsigned ROUND_W     = $clog2(ROUND_COUNT + 1);
   localparam int unsigned WORD_W      = 32;
   localparam int unsigned STATE_WORDS = 12;
   localparam int unsigned COLUMNS     = 4;

   localparam logic [WORD_W-1:0] RC_BASE = 32'h9e37_7900;

   // round phase codes, taken from the low two bits of the round number
   localparam logic [1:0] PHASE_SMALL_SWAP = 2'd0;
   localparam logic [1:0] PHASE_BIG_SWAP   = 2'd2;

   typedef logic [WORD_W-1:0]                    word_type;
   typedef logic [STATE_WORDS-1:0][WORD_W-1:0]   state_type;
   typedef logic [ROUND_W-1:0]                   round_type;

   function automatic word_type round_constant(input round_type round_num);
      round_constant = RC_BASE | word_type'(round_num);
   endfunction

endpackage

/* sv/gimli_spbox_lane.sv */
// ----------------------------------------------------------------------------
// gimli_spbox_lane
// sp-box of one column: rotations plus the nonlinear three-word mix
// ----------------------------------------------------------------------------
module gimli_spbox_lane (
   input  gimli_pkg::word_type top_in,
   input  gimli_pkg::word_type mid_in,
   input  gimli_pkg::word_type bot_in,
   output gimli_pkg::word_type top_out,
   output gimli_pkg::word_type mid_out,
   output gimli_pkg::word_type bot_out
);

   gimli_pkg::word_type x;
   gimli_pkg::word_type y;
   gimli_pkg::word_type z;

   // rotl 24 and rotl 9
   assign x = {top_in[7:0], top_in[31:8]};
   assign y = {mid_in[22:0], mid_in[31:23]};
   assign z = bot_in;

   assign bot_out = x ^ (z << 1) ^ ((y & z) << 2);
   assign mid_out = y ^ x ^ ((x | z) << 1);
   assign top_out = z ^ y ^ ((x & y) << 3);

endmodule

/* sv/gimli_round_stage.sv */
// ----------------------------------------------------------------------------
// gimli_round_stage
// one registered round: four column lanes, then the swap and constant merge
// ----------------------------------------------------------------------------
module gimli_round_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  gimli_pkg::round_type round_num,
   input  logic                 up_valid,
   output logic                 up_ready,
   input  gimli_pkg::state_type up_state,
   output logic                 dn_valid,
   input  logic                 dn_ready,
   output gimli_pkg::state_type dn_state
);

   gimli_pkg::state_type lane_state;
   gimli_pkg::state_type state_in;
   gimli_pkg::state_type state_ff;
   logic                 valid_ff;
   logic                 valid_in;

   for (genvar c = 0; c < gimli_pkg::COLUMNS; c++) begin : g_lane
      gimli_spbox_lane u_lane (
         .top_in  (up_state[c]),
         .mid_in  (up_state[4 + c]),
         .bot_in  (up_state[8 + c]),
         .top_out (lane_state[c]),
         .mid_out (lane_state[4 + c]),
         .bot_out (lane_state[8 + c])
      );
   end

   // merge: row 0 swaps and round constant
   always_comb begin
      state_in = lane_state;
      case (round_num[1:0])
         gimli_pkg::PHASE_SMALL_SWAP: begin
            state_in[0] = lane_state[1] ^ gimli_pkg::round_constant(round_num);
            state_in[1] = lane_state[0];
            state_in[2] = lane_state[3];
            state_in[3] = lane_state[2];
         end
         gimli_pkg::PHASE_BIG_SWAP: begin
            state_in[0] = lane_state[2];
            state_in[1] = lane_state[3];
            state_in[2] = lane_state[0];
            state_in[3] = lane_state[1];
         end
         default: begin
            state_in = lane_state;
         end
      endcase
   end

   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid && up_ready) begin
         state_ff <= state_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_state = state_ff;

endmodule

/* sv/gimli_permutation_core.sv */
// ----------------------------------------------------------------------------
// gimli_permutation_core
// fully pipelined gimli-384 permutation; unstalled, one state per cycle
// ----------------------------------------------------------------------------
// The core takes a 384-bit state as twelve 32-bit words (word 4*r+c is row r,
// column c) and returns the state after the full permutation, rounds counted
// down from gimli_pkg::ROUND_COUNT to 1. Every round is one pipeline stage
// holding four column sp-box lanes side by side and a merge step for the row
// 0 swaps and round constant. A request passes through every stage register
// to the response, and a new request is accepted every cycle unless
// back-pressure stalls the pipe. Each stage holds its own valid bit and
// stalls only when it is full and the stage after it cannot move, so bubbles
// are squeezed out under back-pressure. The last stage register is the
// response register. Requests are independent; nothing is kept between them.
// ----------------------------------------------------------------------------
module gimli_permutation_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_w0,
   input  logic [31:0] req_w1,
   input  logic [31:0] req_w2,
   input  logic [31:0] req_w3,
   input  logic [31:0] req_w4,
   input  logic [31:0] req_w5,
   input  logic [31:0] req_w6,
   input  logic [31:0] req_w7,
   input  logic [31:0] req_w8,
   input  logic [31:0] req_w9,
   input  logic [31:0] req_w10,
   input  logic [31:0] req_w11,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_w0,
   output logic [31:0] rsp_w1,
   output logic [31:0] rsp_w2,
   output logic [31:0] rsp_w3,
   output logic [31:0] rsp_w4,
   output logic [31:0] rsp_w5,
   output logic [31:0] rsp_w6,
   output logic [31:0] rsp_w7,
   output logic [31:0] rsp_w8,
   output logic [31:0] rsp_w9,
   output logic [31:0] rsp_w10,
   output logic [31:0] rsp_w11
);

   localparam int unsigned NSTAGE = gimli_pkg::ROUND_COUNT;

   // pipeline links: index 0 is the request side, NSTAGE the response side
   logic                 link_valid [NSTAGE+1];
   logic                 link_ready [NSTAGE+1];
   gimli_pkg::state_type link_state [NSTAGE+1];

   // request side
   assign link_valid[0] = req_valid;
   assign req_ready     = link_ready[0];
   assign link_state[0] = {req_w11, req_w10, req_w9, req_w8, req_w7, req_w6,
                           req_w5,  req_w4,  req_w3, req_w2, req_w1, req_w0};

   // one stage per round, round number counts down along the pipe
   for (genvar g = 0; g < NSTAGE; g++) begin : g_round
      gimli_round_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .round_num (gimli_pkg::round_type'(NSTAGE - g)),
         .up_valid  (link_valid[g]),
         .up_ready  (link_ready[g]),
         .up_state  (link_state[g]),
         .dn_valid  (link_valid[g+1]),
         .dn_ready  (link_ready[g+1]),
         .dn_state  (link_state[g+1])
      );
   end

   // response side, straight from the last stage register
   assign rsp_valid          = link_valid[NSTAGE];
   assign link_ready[NSTAGE] = rsp_ready;

   assign rsp_w0  = link_state[NSTAGE][0];
   assign rsp_w1  = link_state[NSTAGE][1];
   assign rsp_w2  = link_state[NSTAGE][2];
   assign rsp_w3  = link_state[NSTAGE][3];
   assign rsp_w4  = link_state[NSTAGE][4];
   assign rsp_w5  = link_state[NSTAGE][5];
   assign rsp_w6  = link_state[NSTAGE][6];
   assign rsp_w7  = link_state[NSTAGE][7];
   assign rsp_w8  = link_state[NSTAGE][8];
   assign rsp_w9  = link_state[NSTAGE][9];
   assign rsp_w10 = link_state[NSTAGE][10];
   assign rsp_w11 = link_state[NSTAGE][11];

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// self-checking testbench for the pipelined gimli-384 permutation core
// ----------------------------------------------------------------------------
// Drives 384-bit states into the core over the request channel and checks
// every response word against a behavioral permutation. That model runs in
// the testbench, and its expected results are queued in request order. Phases
// cover:
// - directed corner patterns
// - back-to-back streaming
// - random gaps and stalls on both sides
// - a long response hold that fills the pipeline and stalls the request side
// - sparse and saturated word patterns
// - a final stretch with no idling at all
// ----------------------------------------------------------------------------
module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLOCK_PERIOD   = 8;
   localparam int RESET_CYCLES   = 7;
   localparam int WATCHDOG_LIMIT = 2000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_w0 = '0, req_w1 = '0, req_w2 = '0, req_w3 = '0;
   logic [31:0] req_w4 = '0, req_w5 = '0, req_w6 = '0, req_w7 = '0;
   logic [31:0] req_w8 = '0, req_w9 = '0, req_w10 = '0, req_w11 = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_w0, rsp_w1, rsp_w2, rsp_w3, rsp_w4, rsp_w5;
   logic [31:0] rsp_w6, rsp_w7, rsp_w8, rsp_w9, rsp_w10, rsp_w11;

   // permuted states still owed by the core, oldest first
   gimli_pkg::state_type permuted_fifo[$];

   // traffic shaping knobs, set by the test tasks
   bit request_gaps    = 1'b0;
   bit response_stalls = 1'b0;
   int response_hold_cycles = 0;

   int error_count         = 0;
   int requests_accepted   = 0;
   int responses_checked   = 0;
   int input_stall_run     = 0;
   int longest_input_stall = 0;
   int quiet_cycles        = 0;

   gimli_permutation_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_w0    (req_w0),
      .req_w1    (req_w1),
      .req_w2    (req_w2),
      .req_w3    (req_w3),
      .req_w4    (req_w4),
      .req_w5    (req_w5),
      .req_w6    (req_w6),
      .req_w7    (req_w7),
      .req_w8    (req_w8),
      .req_w9    (req_w9),
      .req_w10   (req_w10),
      .req_w11   (req_w11),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_w0    (rsp_w0),
      .rsp_w1    (rsp_w1),
      .rsp_w2    (rsp_w2),
      .rsp_w3    (rsp_w3),
      .rsp_w4    (rsp_w4),
      .rsp_w5    (rsp_w5),
      .rsp_w6    (rsp_w6),
      .rsp_w7    (rsp_w7),
      .rsp_w8    (rsp_w8),
      .rsp_w9    (rsp_w9),
      .rsp_w10   (rsp_w10),
      .rsp_w11   (rsp_w11)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // --------------------------------------------------------------------------
   // behavioral gimli permutation, rounds counted down to 1
   // --------------------------------------------------------------------------
   function automatic gimli_pkg::state_type gimli_permute(input gimli_pkg::state_type in_state);
      gimli_pkg::state_type st;
      gimli_pkg::word_type  x, y, z, t;
      int                   rnd;
      st = in_state;
      for (rnd = gimli_pkg::ROUND_COUNT; rnd > 0; rnd--) begin
         // sp-box on each column: x from row 0 rotated by 24, y from row 1 by 9
         for (int c = 0; c < gimli_pkg::COLUMNS; c++) begin
            x = {st[c][7:0], st[c][31:8]};
            y = {st[4+c][22:0], st[4+c][31:23]};
            z = st[8+c];
            st[8+c] = x ^ (z << 1) ^ ((y & z) << 2);
            st[4+c] = y ^ x ^ ((x | z) << 1);
            st[c]   = z ^ y ^ ((x & y) << 3);
         end
         if (rnd[1:0] == gimli_pkg::PHASE_SMALL_SWAP) begin
            // small swap of row 0, then the round constant into word 0
            t = st[0]; st[0] = st[1]; st[1] = t;
            t = st[2]; st[2] = st[3]; st[3] = t;
            st[0] = st[0] ^ (gimli_pkg::RC_BASE | gimli_pkg::word_type'(rnd));
         end else if (rnd[1:0] == gimli_pkg::PHASE_BIG_SWAP) begin
            t = st[0]; st[0] = st[2]; st[2] = t;
            t = st[1]; st[1] = st[3]; st[3] = t;
         end
      end
      return st;
   endfunction

   function automatic gimli_pkg::state_type random_state();
      gimli_pkg::state_type st;
      for (int i = 0; i < gimli_pkg::STATE_WORDS; i++) st[i] = $urandom;
      return st;
   endfunction

   // --------------------------------------------------------------------------
   // request side: present one state and hold it until the core takes it
   // --------------------------------------------------------------------------
   task automatic offer_state(input gimli_pkg::state_type st);
      int gap;
      if (request_gaps && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 14);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_w0  <= st[0];  req_w1  <= st[1];  req_w2  <= st[2];  req_w3  <= st[3];
      req_w4  <= st[4];  req_w5  <= st[5];  req_w6  <= st[6];  req_w7  <= st[7];
      req_w8  <= st[8];  req_w9  <= st[9];  req_w10 <= st[10]; req_w11 <= st[11];
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // --------------------------------------------------------------------------
   // response side: random stall bursts, plus a long hold when a test asks
   // --------------------------------------------------------------------------
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (response_hold_cycles > 0) begin
            // long hold counted here so the request side keeps pushing
            stall_left = response_hold_cycles - 1;
            response_hold_cycles = 0;
            rsp_ready <= 1'b0;
         end else if (response_stalls && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 14) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // --------------------------------------------------------------------------
   // monitor: queue the prediction for every accepted request, then compare
   // every accepted response against the oldest one
   // --------------------------------------------------------------------------
   always @(posedge clock) begin
      gimli_pkg::state_type got;
      gimli_pkg::state_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            permuted_fifo.push_back(gimli_permute({req_w11, req_w10, req_w9, req_w8,
                                                   req_w7, req_w6, req_w5, req_w4,
                                                   req_w3, req_w2, req_w1, req_w0}));
            requests_accepted++;
         end
         // track how long the core holds off a waiting request
         if (req_valid && !req_ready) begin
            input_stall_run++;
            if (input_stall_run > longest_input_stall) longest_input_stall = input_stall_run;
         end else begin
            input_stall_run = 0;
         end
         if (rsp_valid && rsp_ready) begin
            got = {rsp_w11, rsp_w10, rsp_w9, rsp_w8, rsp_w7, rsp_w6,
                   rsp_w5, rsp_w4, rsp_w3, rsp_w2, rsp_w1, rsp_w0};
            if (permuted_fifo.size() == 0) begin
               $error("response with no request outstanding: rsp_w0 %h", got[0]);
               error_count++;
            end else begin
               want = permuted_fifo.pop_front();
               for (int i = 0; i < gimli_pkg::STATE_WORDS; i++) begin
                  if (got[i] !== want[i]) begin
                     $error("rsp_w%0d: expected %h, got %h", i, want[i], got[i]);
                     error_count++;
                  end
               end
               responses_checked++;
            end
         end
      end
   end

   // watchdog: any long stretch with no handshake on either side is a hang
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout after %0d quiet cycles, %0d responses still owed",
                  quiet_cycles, permuted_fifo.size());
         $display("gimli_permutation_core: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // --------------------------------------------------------------------------
   // test tasks
   // --------------------------------------------------------------------------

   // all-zero, all-one, alternating, one full word alone, lone edge bits,
   // counting and cubic patterns
   task automatic test_directed_patterns();
      gimli_pkg::state_type st;
      request_gaps    = 1'b0;
      response_stalls = 1'b0;
      offer_state('0);
      offer_state('1);
      offer_state({gimli_pkg::STATE_WORDS{32'h5555_5555}});
      offer_state({gimli_pkg::STATE_WORDS{32'haaaa_aaaa}});
      for (int i = 0; i < gimli_pkg::STATE_WORDS; i++) begin
         st = '0;
         st[i] = '1;
         offer_state(st);
      end
      st = '0;
      st[0][0] = 1'b1;
      offer_state(st);
      st = '0;
      st[gimli_pkg::STATE_WORDS-1][gimli_pkg::WORD_W-1] = 1'b1;
      offer_state(st);
      for (int i = 0; i < gimli_pkg::STATE_WORDS; i++) st[i] = gimli_pkg::word_type'(i);
      offer_state(st);
      for (int i = 0; i < gimli_pkg::STATE_WORDS; i++) st[i] = i * i * i + i * 32'h9e37_79b9;
      offer_state(st);
   endtask

   // one request per cycle while the core is ready, nothing held back
   task automatic test_back_to_back(input int count);
      request_gaps    = 1'b0;
      response_stalls = 1'b0;
      repeat (count) offer_state(random_state());
   endtask

   // random bursts of idling on both channels
   task automatic test_random_gaps(input int count);
      request_gaps    = 1'b1;
      response_stalls = 1'b1;
      repeat (count) offer_state(random_state());
   endtask

   // response side holds off long enough for the pipeline to fill and push
   // back on the request side, which keeps offering throughout
   task automatic test_pipeline_fill(input int hold, input int count);
      request_gaps    = 1'b0;
      response_stalls = 1'b0;
      response_hold_cycles = hold;
      repeat (count) offer_state(random_state());
   endtask

   // words mostly empty or mostly full, mixed with plain random ones
   task automatic test_sparse_words(input int count);
      gimli_pkg::state_type st;
      request_gaps    = 1'b1;
      response_stalls = 1'b1;
      repeat (count) begin
         for (int i = 0; i < gimli_pkg::STATE_WORDS; i++) begin
            case ($urandom_range(0, 4))
               0: st[i] = '0;
               1: st[i] = '1;
               2: st[i] = $urandom & $urandom & $urandom;
               3: st[i] = $urandom | $urandom | $urandom;
               default: st[i] = $urandom;
            endcase
         end
         offer_state(st);
      end
   endtask

   // --------------------------------------------------------------------------
   // main sequence
   // --------------------------------------------------------------------------
   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_patterns();
      test_back_to_back(200);
      test_random_gaps(700);
      test_pipeline_fill(150, 80);
      test_sparse_words(300);
      // closing stretch runs without any idling
      test_back_to_back(150);

      req_valid <= 1'b0;
      while (permuted_fifo.size() != 0) @(posedge clock);
      // give a stray response time to show up
      repeat (gimli_pkg::ROUND_COUNT + 8) @(posedge clock);

      $display("%0d states permuted, %0d responses checked word by word",
               requests_accepted, responses_checked);
      $display("phases: corner patterns, streaming, random idling, sparse words, %0s %0d",
               "pipeline fill with longest request stall of", longest_input_stall);
      if (error_count == 0) begin
         $display("gimli_permutation_core: match");
      end else begin
         $display("gimli_permutation_core: mismatch");
      end
      $finish;
   end

endmodule
